FILE: hw/rtl/dpr_pkg.sv
`timescale 1ns / 1ps
package dpr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DAMP_BITS = 16;
  localparam int MW = 33;                  // multiplier operand width
  localparam int PW = 2 * MW;              // product width
  localparam int QW = FRAC_BITS + 1;       // quotient bits, covers one
  localparam int DVW = 32 + FRAC_BITS;     // dividend width
  localparam int ROOT_ITERS = 32;
  localparam int CW = 6;                   // iteration counter width
  localparam logic [QW-1:0] ONE = QW'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_CLEAR = 3'd1,
    OP_ADD   = 3'd2,
    OP_REPEL = 3'd3,
    OP_DAMP  = 3'd4,
    OP_INTEG = 3'd5
  } op_t;

  localparam logic [1:0] REG_DAMPING_GAIN = 2'd0;
  localparam logic [1:0] REG_REPEL_RADIUS = 2'd1;
  localparam logic [1:0] REG_REPEL_SCALE  = 2'd2;

  typedef struct packed {
    logic start;
    logic div_mode;
  } dpr_cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[PW-1:31];
    hi_zeros = ~|v[PW-1:31];
    if (hi_ones || hi_zeros) return v[31:0];
    else if (v[PW-1]) return 32'sh8000_0000;
    else return 32'sh7fff_ffff;
  endfunction

endpackage

FILE: hw/rtl/damped_particle_repulsion_step.sv
`timescale 1ns / 1ps
// One 3D point mass in signed Q16.16 (position, velocity, force sum) driven by
// one operation per item: load, clear force, add force, repel, damp, integrate.
// Every item returns one result holding the position and velocity after the
// operation and, on repel, the reaction force for the neighbor (zero otherwise).
// Items are taken one at a time. Repel uses the shared root/divide unit: 32 steps
// for the length, 17 steps for each of the falloff and the three unit-vector
// divisions, plus the shared multiplier used twice per axis. The falloff division
// is skipped with radius zero, and all divisions when there is no force.
// Configuration writes are taken every cycle.
module damped_particle_repulsion_step import dpr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         operation,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] vel_z,
  input  logic signed [31:0] force_x,
  input  logic signed [31:0] force_y,
  input  logic signed [31:0] force_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] cur_pos_x,
  output logic signed [31:0] cur_pos_y,
  output logic signed [31:0] cur_pos_z,
  output logic signed [31:0] cur_vel_x,
  output logic signed [31:0] cur_vel_y,
  output logic signed [31:0] cur_vel_z,
  output logic signed [31:0] reaction_x,
  output logic signed [31:0] reaction_y,
  output logic signed [31:0] reaction_z
);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_DIFF  = 16'h0002,
    S_SQ_A  = 16'h0004,
    S_SQ_B  = 16'h0008,
    S_ROOT  = 16'h0010,
    S_PCT   = 16'h0020,
    S_UDIV  = 16'h0040,
    S_MU    = 16'h0080,
    S_MT    = 16'h0100,
    S_MP    = 16'h0200,
    S_MF    = 16'h0400,
    S_DMP_A = 16'h0800,
    S_DMP_B = 16'h1000,
    S_INT_V = 16'h2000,
    S_INT_P = 16'h4000,
    S_FIN   = 16'h8000
  } state_t;

  state_t state;

  logic [15:0]        damping_gain;
  logic [30:0]        repel_radius;
  logic signed [31:0] repel_scale;

  logic signed [31:0] pos [3];
  logic signed [31:0] vel [3];
  logic signed [31:0] frc [3];
  logic signed [31:0] nb [3];
  logic signed [31:0] dd [3];
  logic signed [31:0] react [3];
  logic [1:0]         ax;
  logic [63:0]        sq;
  logic [31:0]        len;
  logic [QW-1:0]      pct;
  logic signed [QW:0] u;
  logic signed [MW-1:0] t;

  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_sh;

  dpr_cmd_t       cmd;
  logic [63:0]    sq_sum;
  logic [DVW-1:0] dividend;
  logic [31:0]    divisor;
  logic           unit_done;
  logic [31:0]    unit_res;
  logic [1:0]     dix;
  logic [31:0]    abs_d;
  logic           no_force;
  logic signed [31:0] f;
  logic signed [QW:0] uq;

  logic in_fire;
  logic out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state == S_FIN) && (!out_valid || out_ready);

  dpr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  dpr_root_div u_unit (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .radicand (sq_sum),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (unit_done),
    .result   (unit_res)
  );

  assign prod_sh = prod >>> FRAC_BITS;
  assign sq_sum  = sq + 64'(prod);
  assign f       = sat32(prod_sh);
  assign uq      = signed'({1'b0, unit_res[QW-1:0]});
  assign no_force = (unit_res == 32'd0) ||
                    ((repel_radius != 31'd0) && (unit_res > {1'b0, repel_radius}));

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQ_A: begin
        mul_a = MW'(dd[ax]);
        mul_b = MW'(dd[ax]);
      end
      S_DMP_A: begin
        mul_a = MW'(vel[ax]);
        mul_b = MW'(damping_gain);
      end
      S_MU: begin
        mul_a = MW'(repel_scale);
        mul_b = MW'(u);
      end
      S_MP: begin
        mul_a = t;
        mul_b = MW'(pct);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // root/divide unit command and operands
  always_comb begin
    dix = (state == S_MF && ax != 2'd2) ? ax + 2'd1 : 2'd0;
    abs_d = dd[dix][31] ? 32'(-dd[dix]) : 32'(dd[dix]);
    cmd.start    = 1'b0;
    cmd.div_mode = 1'b1;
    dividend     = {abs_d, FRAC_BITS'(0)};
    divisor      = len;
    unique case (state)
      S_SQ_B: begin
        cmd.start    = (ax == 2'd2);
        cmd.div_mode = 1'b0;
      end
      S_ROOT: begin
        cmd.start = unit_done && !no_force;
        if (repel_radius == 31'd0) begin
          divisor = unit_res;
        end else begin
          dividend = {unit_res, FRAC_BITS'(0)};
          divisor  = {1'b0, repel_radius};
        end
      end
      S_PCT: cmd.start = unit_done;
      S_MF:  cmd.start = (ax != 2'd2);
      default: cmd.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      damping_gain <= 16'd9175;
      repel_radius <= 31'd6553600;
      repel_scale  <= 32'sd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DAMPING_GAIN: damping_gain <= cfg_data[15:0];
        REG_REPEL_RADIUS: repel_radius <= cfg_data[30:0];
        REG_REPEL_SCALE:  repel_scale  <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
        frc[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready && !out_load) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            ax <= 2'd0;
            for (int i = 0; i < 3; i++) react[i] <= '0;
            unique case (op_t'(operation))
              OP_LOAD: begin
                pos[0] <= pos_x; pos[1] <= pos_y; pos[2] <= pos_z;
                vel[0] <= vel_x; vel[1] <= vel_y; vel[2] <= vel_z;
                state <= S_FIN;
              end
              OP_CLEAR: begin
                for (int i = 0; i < 3; i++) frc[i] <= '0;
                state <= S_FIN;
              end
              OP_ADD: begin
                frc[0] <= sat32(PW'(frc[0]) + PW'(force_x));
                frc[1] <= sat32(PW'(frc[1]) + PW'(force_y));
                frc[2] <= sat32(PW'(frc[2]) + PW'(force_z));
                state <= S_FIN;
              end
              OP_REPEL: begin
                nb[0] <= pos_x; nb[1] <= pos_y; nb[2] <= pos_z;
                state <= S_DIFF;
              end
              OP_DAMP:  state <= S_DMP_A;
              OP_INTEG: state <= S_INT_V;
              default:  state <= S_FIN;
            endcase
          end
        end
        S_DIFF: begin
          for (int i = 0; i < 3; i++) dd[i] <= sat32(PW'(pos[i]) - PW'(nb[i]));
          sq    <= '0;
          state <= S_SQ_A;
        end
        S_SQ_A: state <= S_SQ_B;
        S_SQ_B: begin
          sq <= sq_sum;
          if (ax == 2'd2) begin
            state <= S_ROOT;
          end else begin
            ax    <= ax + 2'd1;
            state <= S_SQ_A;
          end
        end
        S_ROOT: begin
          if (unit_done) begin
            len <= unit_res;
            ax  <= 2'd0;
            if (no_force) begin
              state <= S_FIN;
            end else if (repel_radius == 31'd0) begin
              pct   <= ONE;
              state <= S_UDIV;
            end else begin
              state <= S_PCT;
            end
          end
        end
        S_PCT: begin
          if (unit_done) begin
            pct   <= ONE - unit_res[QW-1:0];
            state <= S_UDIV;
          end
        end
        S_UDIV: begin
          if (unit_done) begin
            u     <= dd[ax][31] ? -uq : uq;
            state <= S_MU;
          end
        end
        S_MU: state <= S_MT;
        S_MT: begin
          t     <= prod_sh[MW-1:0];
          state <= S_MP;
        end
        S_MP: state <= S_MF;
        S_MF: begin
          frc[ax]   <= sat32(PW'(frc[ax]) + PW'(f));
          react[ax] <= sat32(-PW'(f));
          if (ax == 2'd2) begin
            state <= S_FIN;
          end else begin
            ax    <= ax + 2'd1;
            state <= S_UDIV;
          end
        end
        S_DMP_A: state <= S_DMP_B;
        S_DMP_B: begin
          frc[ax] <= sat32(PW'(frc[ax]) - PW'(prod >>> DAMP_BITS));
          if (ax == 2'd2) begin
            state <= S_FIN;
          end else begin
            ax    <= ax + 2'd1;
            state <= S_DMP_A;
          end
        end
        S_INT_V: begin
          for (int i = 0; i < 3; i++) vel[i] <= sat32(PW'(vel[i]) + PW'(frc[i]));
          state <= S_INT_P;
        end
        S_INT_P: begin
          for (int i = 0; i < 3; i++) pos[i] <= sat32(PW'(pos[i]) + PW'(vel[i]));
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (out_load) begin
      cur_pos_x  <= pos[0];
      cur_pos_y  <= pos[1];
      cur_pos_z  <= pos[2];
      cur_vel_x  <= vel[0];
      cur_vel_y  <= vel[1];
      cur_vel_z  <= vel[2];
      reaction_x <= react[0];
      reaction_y <= react[1];
      reaction_z <= react[2];
    end
  end

endmodule

FILE: hw/rtl/dpr_mul.sv
`timescale 1ns / 1ps
module dpr_mul import dpr_pkg::*; (
  input  logic                 clk,
  input  logic signed [MW-1:0] a,
  input  logic signed [MW-1:0] b,
  output logic signed [PW-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

FILE: hw/rtl/dpr_root_div.sv
`timescale 1ns / 1ps
module dpr_root_div import dpr_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  dpr_cmd_t       cmd,
  input  logic [63:0]    radicand,
  input  logic [DVW-1:0] dividend,
  input  logic [31:0]    divisor,
  output logic           done,
  output logic [31:0]    result
);

  logic          busy;
  logic          mode;
  logic [CW-1:0] cnt;
  logic [63:0]   x;
  logic [63:0]   res;
  logic [63:0]   rbit;
  logic [31:0]   rem;
  logic [31:0]   dvs;
  logic [QW-1:0] shreg;
  logic [64:0]   rtrial;
  logic [32:0]   dtrial;

  assign rtrial = {1'b0, res} + {1'b0, rbit};
  assign dtrial = {rem, shreg[QW-1]};
  assign result = mode ? 32'(shreg) : res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.div_mode ? CW'(QW) : CW'(ROOT_ITERS);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode  <= cmd.div_mode;
      x     <= radicand;
      res   <= '0;
      rbit  <= 64'h1 << 62;
      // quotient fits QW bits, so the upper dividend part is below the divisor
      rem   <= 32'(dividend[DVW-1:QW]);
      shreg <= dividend[QW-1:0];
      dvs   <= divisor;
    end else if (busy) begin
      if (mode) begin
        if (dtrial >= {1'b0, dvs}) begin
          rem   <= 32'(dtrial - {1'b0, dvs});
          shreg <= {shreg[QW-2:0], 1'b1};
        end else begin
          rem   <= dtrial[31:0];
          shreg <= {shreg[QW-2:0], 1'b0};
        end
      end else begin
        if ({1'b0, x} >= rtrial) begin
          x   <= x - rtrial[63:0];
          res <= (res >> 1) + rbit;
        end else begin
          res <= res >> 1;
        end
        rbit <= rbit >> 2;
      end
    end
  end

endmodule

FILE: hw/rtl/dpr_checker.sv
`timescale 1ns / 1ps
module dpr_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] cur_pos_x,
  input logic signed [31:0] reaction_x
);

  // block is busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while previous item still in work");

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(cur_pos_x) && $stable(reaction_x))
    else $error("result changed while stalled");

endmodule

bind damped_particle_repulsion_step dpr_checker u_dpr_checker (.*);

FILE: sim/damped_particle_repulsion_step_tb.sv
`timescale 1ns / 1ps
module damped_particle_repulsion_step_tb;
  import dpr_pkg::*;

  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] p [3];
    logic signed [31:0] v [3];
    logic signed [31:0] f [3];
  } particle_cmd_t;

  typedef struct {
    logic signed [31:0] p [3];
    logic signed [31:0] v [3];
    logic signed [31:0] r [3];
  } particle_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] operation = '0;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [31:0] vel_x = '0, vel_y = '0, vel_z = '0;
  logic signed [31:0] force_x = '0, force_y = '0, force_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] cur_pos_x, cur_pos_y, cur_pos_z;
  logic signed [31:0] cur_vel_x, cur_vel_y, cur_vel_z;
  logic signed [31:0] reaction_x, reaction_y, reaction_z;

  damped_particle_repulsion_step u_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0] m_pos [3];
  logic signed [31:0] m_vel [3];
  logic signed [31:0] m_frc [3];
  logic [15:0] m_gain;
  logic [30:0] m_radius;
  logic signed [31:0] m_scale;
  logic signed [31:0] m_pos_guess [3] = '{0, 0, 0};

  particle_cmd_t pending_items[$];
  particle_state_t expected_states[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int repel_hits = 0;

  function automatic logic signed [31:0] clip32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7fff_ffff;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic longint floor_shift(input longint x, input int s);
    return x >>> s;
  endfunction

  function automatic longint unsigned isqrt(input longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic particle_state_t advance_particle(input particle_cmd_t c);
    particle_state_t s;
    longint d [3];
    longint unsigned sq, len;
    longint pct, u, t;
    logic signed [31:0] fv;
    for (int i = 0; i < 3; i++) s.r[i] = '0;
    case (c.op)
      OP_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          m_pos[i] = c.p[i];
          m_vel[i] = c.v[i];
        end
      end
      OP_CLEAR: for (int i = 0; i < 3; i++) m_frc[i] = '0;
      OP_ADD: for (int i = 0; i < 3; i++) m_frc[i] = clip32(longint'(m_frc[i]) + c.f[i]);
      OP_REPEL: begin
        sq = 0;
        for (int i = 0; i < 3; i++) begin
          d[i] = clip32(longint'(m_pos[i]) - longint'(c.p[i]));
          sq += longint'(d[i] * d[i]);
        end
        len = isqrt(sq);
        if (len != 0 && !(m_radius != 0 && len > m_radius)) begin
          repel_hits++;
          pct = 65536;
          if (m_radius != 0) pct = 65536 - longint'((len << 16) / m_radius);
          for (int i = 0; i < 3; i++) begin
            u = (d[i] * 65536) / longint'(len);
            t = floor_shift(u * longint'(m_scale), 16);
            fv = clip32(floor_shift(t * pct, 16));
            m_frc[i] = clip32(longint'(m_frc[i]) + fv);
            s.r[i] = clip32(-longint'(fv));
          end
        end
      end
      OP_DAMP: begin
        for (int i = 0; i < 3; i++)
          m_frc[i] = clip32(longint'(m_frc[i]) -
                            floor_shift(longint'(m_vel[i]) * longint'({1'b0, m_gain}), 16));
      end
      OP_INTEG: begin
        for (int i = 0; i < 3; i++) begin
          m_vel[i] = clip32(longint'(m_vel[i]) + m_frc[i]);
          m_pos[i] = clip32(longint'(m_pos[i]) + m_vel[i]);
        end
      end
      default: ;
    endcase
    for (int i = 0; i < 3; i++) begin
      s.p[i] = m_pos[i];
      s.v[i] = m_vel[i];
    end
    return s;
  endfunction

  // sender: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_states.push_back(advance_particle(pending_items.pop_front()));
        items_sent++;
      end
      if (in_valid && !in_ready) begin
        // hold the item
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        particle_cmd_t c;
        c = pending_items[0];
        in_valid <= 1'b1;
        operation <= c.op;
        pos_x <= c.p[0]; pos_y <= c.p[1]; pos_z <= c.p[2];
        vel_x <= c.v[0]; vel_y <= c.v[1]; vel_z <= c.v[2];
        force_x <= c.f[0]; force_y <= c.f[1]; force_z <= c.f[2];
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern of its own
  int stall_phase = 0;
  always @(posedge clk) begin
    if (!rst) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 512 < 128) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic check_field(input string nm, input logic signed [31:0] exp_v,
                             input logic signed [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d actual %0d", $time, nm, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      particle_state_t e;
      results_seen++;
      if (expected_states.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected", $time);
      end else begin
        e = expected_states.pop_front();
        check_field("cur_pos_x", e.p[0], cur_pos_x);
        check_field("cur_pos_y", e.p[1], cur_pos_y);
        check_field("cur_pos_z", e.p[2], cur_pos_z);
        check_field("cur_vel_x", e.v[0], cur_vel_x);
        check_field("cur_vel_y", e.v[1], cur_vel_y);
        check_field("cur_vel_z", e.v[2], cur_vel_z);
        check_field("reaction_x", e.r[0], reaction_x);
        check_field("reaction_y", e.r[1], reaction_y);
        check_field("reaction_z", e.r[2], reaction_z);
      end
    end
  end

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 32'($urandom);
      3: return 32'($urandom);
      default: return $signed(32'($urandom_range(0, 32'h0020_0000))) - 32'sh0010_0000;
    endcase
  endfunction

  task automatic queue_item(input logic [2:0] op, input logic signed [31:0] a,
                            input logic signed [31:0] b, input logic signed [31:0] cc);
    particle_cmd_t c;
    c.op = op;
    for (int i = 0; i < 3; i++) begin
      c.p[i] = rand_word();
      c.v[i] = rand_word();
      c.f[i] = rand_word();
    end
    c.p[0] = a; c.p[1] = b; c.p[2] = cc;
    pending_items.push_back(c);
  endtask

  task automatic queue_random(input int n);
    for (int k = 0; k < n; k++) begin
      particle_cmd_t c;
      c.op = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 9) < 8 && c.op > OP_INTEG) c.op = OP_REPEL;
      for (int i = 0; i < 3; i++) begin
        c.p[i] = rand_word();
        c.v[i] = rand_word();
        c.f[i] = rand_word();
      end
      // most repels use a nearby neighbor so the force path is reached
      if (c.op == OP_REPEL && $urandom_range(0, 3) != 0)
        for (int i = 0; i < 3; i++)
          c.p[i] = m_pos_guess[i] + $signed(32'($urandom_range(0, 32'h000c_0000))) - 32'sh6_0000;
      if (c.op == OP_LOAD && $urandom_range(0, 1) == 0)
        for (int i = 0; i < 3; i++) begin
          c.p[i] = $signed(32'($urandom_range(0, 32'h0100_0000))) - 32'sh80_0000;
          c.v[i] = $signed(32'($urandom_range(0, 32'h0004_0000))) - 32'sh2_0000;
        end
      if (c.op == OP_LOAD)
        for (int i = 0; i < 3; i++) m_pos_guess[i] = c.p[i];
      pending_items.push_back(c);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DAMPING_GAIN: m_gain = val[15:0];
      REG_REPEL_RADIUS: m_radius = val[30:0];
      default: m_scale = val;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || expected_states.size() > 0 || in_valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < 3; i++) begin
      m_pos[i] = '0; m_vel[i] = '0; m_frc[i] = '0;
    end
    m_gain = 16'd9175;
    m_radius = 31'd6553600;
    m_scale = 32'sd65536;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: every operation, extremes, zero distance, unused codes
    queue_item(OP_REPEL, 0, 0, 0);
    queue_item(OP_LOAD, 32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000);
    queue_item(OP_REPEL, 32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000);
    queue_item(OP_REPEL, 0, 0, 0);
    queue_item(OP_REPEL, 32'sh0001_8000, 32'sh0002_0000, -32'sh0003_0000);
    queue_item(OP_ADD, 0, 0, 0);
    queue_item(OP_DAMP, 0, 0, 0);
    queue_item(OP_INTEG, 0, 0, 0);
    queue_item(3'd6, 0, 0, 0);
    queue_item(3'd7, 0, 0, 0);
    queue_item(OP_CLEAR, 0, 0, 0);
    queue_item(OP_LOAD, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    queue_item(OP_REPEL, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
    queue_item(OP_INTEG, 0, 0, 0);
    queue_item(OP_DAMP, 0, 0, 0);
    queue_item(OP_INTEG, 0, 0, 0);
    queue_item(OP_LOAD, 0, 0, 0);
    queue_item(OP_CLEAR, 0, 0, 0);
    drain();

    // sender held until everything is back between phases
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_DAMPING_GAIN, 32'hffff);
          write_reg(REG_REPEL_RADIUS, 32'h7fff_ffff);
          write_reg(REG_REPEL_SCALE, 32'h7fff_ffff);
        end
        1: begin
          write_reg(REG_DAMPING_GAIN, 32'h0);
          write_reg(REG_REPEL_RADIUS, 32'h0);
          write_reg(REG_REPEL_SCALE, 32'h8000_0000);
        end
        2: begin
          write_reg(REG_DAMPING_GAIN, 32'd9175);
          write_reg(REG_REPEL_RADIUS, 32'h0001_0000);
          write_reg(REG_REPEL_SCALE, 32'h0);
        end
        default: begin
          write_reg(REG_DAMPING_GAIN, $urandom);
          write_reg(REG_REPEL_RADIUS, ($urandom_range(0, 1) == 0) ? 32'h0 :
                    32'($urandom_range(32'h1000, 32'h0040_0000)));
          write_reg(REG_REPEL_SCALE, $urandom);
        end
      endcase
      queue_random(240);
      drain();
    end

    $display("covered %0d items, %0d results, %0d repels inside the radius",
             items_sent, results_seen, repel_hits);
    $display("six register settings incl. zero radius and scale extremes");
    if (errors == 0) begin
      $display("damped_particle_repulsion_step regression: pass");
    end else begin
      $display("damped_particle_repulsion_step regression: fail");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("damped_particle_repulsion_step regression: fail");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/dpr_pkg.sv
hw/rtl/dpr_mul.sv
hw/rtl/dpr_root_div.sv
hw/rtl/damped_particle_repulsion_step.sv
hw/rtl/dpr_checker.sv
sim/damped_particle_repulsion_step_tb.sv
